@@ rtl/pool_chunk_allocator_unit_assert.svh @@
// Assertion macros for the pool chunk allocator unit.
// Included by the top level; needs nothing else.
`ifndef POOL_CHUNK_ALLOCATOR_UNIT_ASSERT_SVH
`define POOL_CHUNK_ALLOCATOR_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Condition in the same cycle implies the consequence in the same cycle.
`define PCA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pool chunk allocator check failed");
// Condition in one cycle implies the consequence in the next cycle.
`define PCA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pool chunk allocator check failed");
`else
`define PCA_ASSERT_NOW(label, clk, rst, ante, cons)
`define PCA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ rtl/pca_pkg.sv @@
// Shared types, codes and sizes of the pool chunk allocator.
// Used by every module of the block; depends on nothing.
`default_nettype none

package pca_pkg;

   localparam int unsigned POOL_CHUNKS = 1024;
   localparam int unsigned COUNT_WIDTH = $clog2(POOL_CHUNKS + 1);
   localparam int unsigned ADDR_WIDTH  = $clog2(POOL_CHUNKS);
   localparam int unsigned IDX_WIDTH   = 10;
   localparam int unsigned CPB_WIDTH   = 11;
   localparam int unsigned CB_WIDTH    = 13;
   localparam int unsigned BYTES_WIDTH = 23;
   localparam int unsigned BLK_WIDTH   = 4;
   localparam int unsigned BLOCKS_MAX  = 15;
   // First-block size shifted by at most BLOCKS_MAX - 1.
   localparam int unsigned SIZE_WIDTH  = CPB_WIDTH + BLOCKS_MAX - 1;
   localparam int unsigned CSR_WIDTH   = 1;
   localparam int unsigned CSR_DATA_WIDTH = 13;
   localparam int unsigned CPB_RESET   = 16;
   localparam int unsigned CB_RESET    = 16;

   typedef enum logic [0:0] {
      OP_ALLOCATE = 1'b0,
      OP_RELEASE  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_EXHAUSTED = 2'd1,
      STATUS_OVERFLOW  = 2'd2
   } status_type;

   typedef enum logic [CSR_WIDTH-1:0] {
      CSR_CHUNKS_PER_BLOCK = 1'b0,
      CSR_CHUNK_BYTES      = 1'b1
   } csr_index_type;

   typedef struct packed {
      op_type               op;
      logic [IDX_WIDTH-1:0] chunk_index;
   } req_payload_type;

   typedef struct packed {
      logic [IDX_WIDTH-1:0]   granted_index;
      status_type             status;
      logic [BYTES_WIDTH-1:0] pool_bytes;
      logic [BLK_WIDTH-1:0]   blocks_opened;
   } rsp_payload_type;

   typedef struct packed {
      logic [CPB_WIDTH-1:0] chunks_per_block;
      logic [CB_WIDTH-1:0]  chunk_bytes;
   } cfg_type;

   typedef struct packed {
      logic                 push;
      logic                 pop;
      logic [IDX_WIDTH-1:0] push_index;
   } stack_ctrl_type;

   typedef struct packed {
      logic [COUNT_WIDTH-1:0] count;
      logic [IDX_WIDTH-1:0]   top;
   } stack_status_type;

endpackage

`default_nettype wire

@@ rtl/pool_chunk_allocator_unit.sv @@
// Top level of the pool chunk allocator: handshake, configuration registers,
// result register. Depends on pca_pkg, pca_core, pca_free_stack and the assert header.
//
//   Channel   Ports                                     Direction  Moves
//   req       req_valid, req_ready, req_payload         in         one request per transfer
//   rsp       rsp_valid, rsp_ready, rsp_payload         out        one result per transfer
//   csr       csr_write_enable, csr_index, csr_write_data  in      one register write
//
// A request is decided in the cycle of its transfer and its result shows on rsp in the
// next cycle, so with rsp_ready held high the unit takes one request every cycle.
// That figure is set by the free stack, which keeps its two top entries in registers
// and refills the second from a memory with a registered read on every pop.
// The synchronous reset empties the free stack and closes all blocks; no clearing pass.
// A stalled result holds in the output register; a new request is taken whenever that
// register is empty or is being drained in the same cycle.
`default_nettype none
`include "pool_chunk_allocator_unit_assert.svh"

module pool_chunk_allocator_unit (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire pca_pkg::req_payload_type             req_payload,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output pca_pkg::rsp_payload_type                  rsp_payload,
   input  wire logic                                 csr_write_enable,
   input  wire logic [pca_pkg::CSR_WIDTH-1:0]        csr_index,
   input  wire logic [pca_pkg::CSR_DATA_WIDTH-1:0]   csr_write_data
);

   pca_pkg::cfg_type          cfg_ff;
   pca_pkg::stack_ctrl_type   stack_ctrl;
   pca_pkg::stack_status_type stack_status;
   pca_pkg::rsp_payload_type  rsp_next;
   pca_pkg::rsp_payload_type  rsp_payload_ff;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   logic                      req_fire;

   // The output register can take a new result when it is empty or being drained.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   // Configuration writes land at once; they only matter when the next block opens.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.chunks_per_block <= pca_pkg::CPB_WIDTH'(pca_pkg::CPB_RESET);
         cfg_ff.chunk_bytes      <= pca_pkg::CB_WIDTH'(pca_pkg::CB_RESET);
      end else if (csr_write_enable) begin
         unique case (csr_index)
            pca_pkg::CSR_CHUNKS_PER_BLOCK: begin
               cfg_ff.chunks_per_block <= csr_write_data[pca_pkg::CPB_WIDTH-1:0];
            end
            pca_pkg::CSR_CHUNK_BYTES: begin
               cfg_ff.chunk_bytes <= csr_write_data[pca_pkg::CB_WIDTH-1:0];
            end
            default: begin
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

   pca_core u_core (
      .clock (clock),
      .reset (reset),
      .fire  (req_fire),
      .req   (req_payload),
      .cfg   (cfg_ff),
      .stack (stack_status),
      .ctrl  (stack_ctrl),
      .rsp   (rsp_next)
   );

   pca_free_stack u_free_stack (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (stack_ctrl),
      .status (stack_status)
   );

   // Result register: filled on a request transfer, emptied on a result transfer.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_payload_ff <= rsp_next;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // Every request transfer leaves a result waiting in the next cycle.
   `PCA_ASSERT_NEXT(a_fire_gives_result, clock, reset, req_fire, rsp_valid)
   // The free stack never holds more than the index space.
   `PCA_ASSERT_NOW(a_stack_bounded, clock, reset, 1'b1,
      stack_status.count <= pca_pkg::COUNT_WIDTH'(pca_pkg::POOL_CHUNKS))
   // A release into a stack with room is always reported as ok.
   `PCA_ASSERT_NEXT(a_release_ok, clock, reset,
      req_fire && (req_payload.op == pca_pkg::OP_RELEASE)
         && (stack_status.count != pca_pkg::COUNT_WIDTH'(pca_pkg::POOL_CHUNKS)),
      rsp_payload.status == pca_pkg::STATUS_OK)

endmodule

`default_nettype wire

@@ rtl/pca_free_stack.sv @@
// LIFO free stack of released chunk indexes, one push or pop per cycle.
// Depends on pca_pkg for sizes and the control and status structs.
`default_nettype none

module pca_free_stack (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire pca_pkg::stack_ctrl_type   ctrl,
   output pca_pkg::stack_status_type      status
);

   // The two top entries live in registers; the memory holds the rest, so a pop
   // has its new top ready and starts the registered read of the one below.
   logic [pca_pkg::IDX_WIDTH-1:0]   mem [pca_pkg::POOL_CHUNKS];
   logic [pca_pkg::COUNT_WIDTH-1:0] count_ff;
   logic [pca_pkg::COUNT_WIDTH-1:0] count_in;
   logic [pca_pkg::IDX_WIDTH-1:0]   top_ff;
   logic [pca_pkg::IDX_WIDTH-1:0]   second_ff;
   logic [pca_pkg::COUNT_WIDTH-1:0] wr_sum;
   logic [pca_pkg::COUNT_WIDTH-1:0] rd_sum;
   logic [pca_pkg::ADDR_WIDTH-1:0]  wr_addr;
   logic [pca_pkg::ADDR_WIDTH-1:0]  rd_addr;

   assign wr_sum  = count_ff - pca_pkg::COUNT_WIDTH'(1);
   assign rd_sum  = count_ff - pca_pkg::COUNT_WIDTH'(3);
   assign wr_addr = wr_sum[pca_pkg::ADDR_WIDTH-1:0];
   assign rd_addr = rd_sum[pca_pkg::ADDR_WIDTH-1:0];

   always_comb begin
      count_in = count_ff;
      if (ctrl.push) begin
         count_in = count_ff + pca_pkg::COUNT_WIDTH'(1);
      end else if (ctrl.pop) begin
         count_in = count_ff - pca_pkg::COUNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         mem[wr_addr] <= top_ff;
         second_ff    <= top_ff;
         top_ff       <= ctrl.push_index;
      end else if (ctrl.pop) begin
         top_ff    <= second_ff;
         second_ff <= mem[rd_addr];
      end
   end

   assign status.count = count_ff;
   assign status.top   = top_ff;

endmodule

`default_nettype wire

@@ rtl/pca_core.sv @@
// Allocation decision and block bump state of the pool chunk allocator.
// Depends on pca_pkg; drives the free stack and the result register.
`default_nettype none

module pca_core (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       fire,
   input  wire pca_pkg::req_payload_type   req,
   input  wire pca_pkg::cfg_type           cfg,
   input  wire pca_pkg::stack_status_type  stack,
   output pca_pkg::stack_ctrl_type         ctrl,
   output pca_pkg::rsp_payload_type        rsp
);

   localparam int unsigned PROD_WIDTH = pca_pkg::COUNT_WIDTH + pca_pkg::CB_WIDTH;

   logic [pca_pkg::COUNT_WIDTH-1:0] next_fresh_ff, next_fresh_in;
   logic [pca_pkg::COUNT_WIDTH-1:0] block_limit_ff, block_limit_in;
   logic [pca_pkg::BLK_WIDTH-1:0]   block_count_ff, block_count_in;
   logic [pca_pkg::BYTES_WIDTH-1:0] total_bytes_ff, total_bytes_in;

   logic                             need_block;
   logic                             block_fits;
   logic [pca_pkg::SIZE_WIDTH-1:0]   size_wide;
   logic [pca_pkg::SIZE_WIDTH:0]     limit_sum;
   logic [PROD_WIDTH-1:0]            product;
   logic [PROD_WIDTH:0]              bytes_sum;
   logic [pca_pkg::COUNT_WIDTH-1:0]  fresh_base;

   assign need_block = next_fresh_ff >= block_limit_ff;
   assign size_wide  = pca_pkg::SIZE_WIDTH'(cfg.chunks_per_block) << block_count_ff;
   assign limit_sum  = (pca_pkg::SIZE_WIDTH + 1)'(block_limit_ff)
                       + (pca_pkg::SIZE_WIDTH + 1)'(size_wide);
   assign block_fits = (block_count_ff != pca_pkg::BLK_WIDTH'(pca_pkg::BLOCKS_MAX))
                       && (size_wide != '0)
                       && (limit_sum <= (pca_pkg::SIZE_WIDTH + 1)'(pca_pkg::POOL_CHUNKS));
   // A block that fits has at most POOL_CHUNKS chunks, so the low bits are the size.
   assign product    = size_wide[pca_pkg::COUNT_WIDTH-1:0] * PROD_WIDTH'(cfg.chunk_bytes);
   assign bytes_sum  = (PROD_WIDTH + 1)'(total_bytes_ff) + (PROD_WIDTH + 1)'(product);
   assign fresh_base = need_block ? block_limit_ff : next_fresh_ff;

   always_comb begin
      next_fresh_in   = next_fresh_ff;
      block_limit_in  = block_limit_ff;
      block_count_in  = block_count_ff;
      total_bytes_in  = total_bytes_ff;
      ctrl.push       = 1'b0;
      ctrl.pop        = 1'b0;
      ctrl.push_index = req.chunk_index;
      rsp.granted_index = '0;
      rsp.status        = pca_pkg::STATUS_OK;
      if (fire) begin
         case (req.op)
            pca_pkg::OP_ALLOCATE: begin
               if (stack.count != '0) begin
                  ctrl.pop          = 1'b1;
                  rsp.granted_index = stack.top;
               end else if (need_block && !block_fits) begin
                  rsp.status = pca_pkg::STATUS_EXHAUSTED;
               end else begin
                  if (need_block) begin
                     block_limit_in = limit_sum[pca_pkg::COUNT_WIDTH-1:0];
                     block_count_in = block_count_ff + pca_pkg::BLK_WIDTH'(1);
                     // Saturate the byte total at its field maximum.
                     if (bytes_sum[PROD_WIDTH:pca_pkg::BYTES_WIDTH] != '0) begin
                        total_bytes_in = '1;
                     end else begin
                        total_bytes_in = bytes_sum[pca_pkg::BYTES_WIDTH-1:0];
                     end
                  end
                  rsp.granted_index = fresh_base[pca_pkg::IDX_WIDTH-1:0];
                  next_fresh_in     = fresh_base + pca_pkg::COUNT_WIDTH'(1);
               end
            end
            pca_pkg::OP_RELEASE: begin
               if (stack.count == pca_pkg::COUNT_WIDTH'(pca_pkg::POOL_CHUNKS)) begin
                  rsp.status = pca_pkg::STATUS_OVERFLOW;
               end else begin
                  ctrl.push = 1'b1;
               end
            end
            default: begin
               rsp.status = pca_pkg::STATUS_OK;
            end
         endcase
      end
      rsp.pool_bytes    = total_bytes_in;
      rsp.blocks_opened = block_count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_fresh_ff  <= '0;
         block_limit_ff <= '0;
         block_count_ff <= '0;
         total_bytes_ff <= '0;
      end else begin
         next_fresh_ff  <= next_fresh_in;
         block_limit_ff <= block_limit_in;
         block_count_ff <= block_count_in;
         total_bytes_ff <= total_bytes_in;
      end
   end

endmodule

`default_nettype wire

@@ verif/pool_chunk_allocator_unit_checker.sv @@
`timescale 1ns / 1ps
// Checker for the pool chunk allocator unit: it watches the req, rsp and csr ports,
// predicts each result and compares it with the result the unit returns.
// Depends on pca_pkg only.

module pool_chunk_allocator_unit_checker
   import pca_pkg::*;
(
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   input  wire logic                          req_ready,
   input  wire req_payload_type               req_payload,
   input  wire logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   input  wire rsp_payload_type               rsp_payload,
   input  wire logic                          csr_write_enable,
   input  wire logic [CSR_WIDTH-1:0]          csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]     csr_write_data,
   output int unsigned                        mismatch_count,
   output int unsigned                        pending_replies
);

   localparam longint unsigned BYTE_TOTAL_CAP = (64'd1 << BYTES_WIDTH) - 1;
   localparam int unsigned REPORT_LIMIT = 10;

   // Shadow copy of the allocator state and its two registers.
   logic [IDX_WIDTH-1:0] free_list [POOL_CHUNKS];
   int unsigned          free_depth;
   int unsigned          fresh_next;
   int unsigned          fill_limit;
   int unsigned          opened_blocks;
   longint unsigned      byte_total;
   logic [CPB_WIDTH-1:0] first_block_chunks;
   logic [CB_WIDTH-1:0]  bytes_per_chunk;

   rsp_payload_type      predicted_replies [$];
   int unsigned          failures;

   initial begin
      failures = 0;
      mismatch_count = 0;
      pending_replies = 0;
   end

   // Works out the reply to one request and advances the shadow state.
   task automatic predict_reply(input req_payload_type rq, output rsp_payload_type rs);
      longint unsigned grow_chunks;
      longint unsigned new_total;
      rs = '0;
      rs.status = STATUS_OK;
      grow_chunks = first_block_chunks;
      grow_chunks = grow_chunks << opened_blocks;
      if (rq.op == OP_RELEASE) begin
         if (free_depth >= POOL_CHUNKS) begin
            rs.status = STATUS_OVERFLOW;
         end else begin
            free_list[free_depth] = rq.chunk_index;
            free_depth++;
         end
      end else if (free_depth > 0) begin
         free_depth--;
         rs.granted_index = free_list[free_depth];
      end else if (fresh_next >= fill_limit &&
                   (opened_blocks >= BLOCKS_MAX || grow_chunks == 0 ||
                    fill_limit + grow_chunks > POOL_CHUNKS)) begin
         rs.status = STATUS_EXHAUSTED;
      end else begin
         if (fresh_next >= fill_limit) begin
            new_total = byte_total + grow_chunks * bytes_per_chunk;
            byte_total = (new_total > BYTE_TOTAL_CAP) ? BYTE_TOTAL_CAP : new_total;
            fresh_next = fill_limit;
            fill_limit = fill_limit + int'(grow_chunks);
            opened_blocks++;
         end
         rs.granted_index = fresh_next[IDX_WIDTH-1:0];
         fresh_next++;
      end
      rs.pool_bytes = byte_total[BYTES_WIDTH-1:0];
      rs.blocks_opened = opened_blocks[BLK_WIDTH-1:0];
   endtask

   task automatic compare_reply(input rsp_payload_type want, input rsp_payload_type got);
      if (got.granted_index !== want.granted_index || got.status !== want.status ||
          got.pool_bytes !== want.pool_bytes || got.blocks_opened !== want.blocks_opened)
      begin
         failures++;
         if (failures <= REPORT_LIMIT) begin
            $display("%0t result differs: expected index %0d status %0d bytes %0d blocks %0d,",
                     $realtime, want.granted_index, want.status, want.pool_bytes,
                     want.blocks_opened);
            $display("   got index %0d status %0d bytes %0d blocks %0d", got.granted_index,
                     got.status, got.pool_bytes, got.blocks_opened);
         end
      end
   endtask

   always @(posedge clock) begin
      rsp_payload_type fresh_reply;
      rsp_payload_type oldest_reply;
      if (reset) begin
         free_depth = 0;
         fresh_next = 0;
         fill_limit = 0;
         opened_blocks = 0;
         byte_total = 0;
         first_block_chunks = CPB_WIDTH'(CPB_RESET);
         bytes_per_chunk = CB_WIDTH'(CB_RESET);
         predicted_replies.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_CHUNKS_PER_BLOCK: first_block_chunks = csr_write_data[CPB_WIDTH-1:0];
               CSR_CHUNK_BYTES:      bytes_per_chunk = csr_write_data[CB_WIDTH-1:0];
               default: ;
            endcase
         end
         // A request is queued before the reply check so a same-cycle reply would match it.
         if (req_valid && req_ready) begin
            predict_reply(req_payload, fresh_reply);
            predicted_replies.insert(predicted_replies.size(), fresh_reply);
         end
         if (rsp_valid && rsp_ready) begin
            if (predicted_replies.size() == 0) begin
               failures++;
               if (failures <= REPORT_LIMIT)
                  $display("%0t result with nothing expected: index %0d status %0d",
                           $realtime, rsp_payload.granted_index, rsp_payload.status);
            end else begin
               oldest_reply = predicted_replies[0];
               predicted_replies.delete(0);
               compare_reply(oldest_reply, rsp_payload);
            end
         end
      end
      pending_replies <= predicted_replies.size();
      mismatch_count <= failures;
   end

endmodule

@@ verif/pool_chunk_allocator_unit_test.sv @@
`timescale 1ns / 1ps
// Testbench top for the pool chunk allocator unit: drives requests and register writes,
// throttles the result channel, and gives the verdict. Depends on pca_pkg, the unit
// and pool_chunk_allocator_unit_checker.

module pool_chunk_allocator_unit_test;
   import pca_pkg::*;

   // Longest stretch without any transfer before the run is declared hung. The longest
   // legal stall is the receiver's forced hold plus a register write, far below this.
   localparam int unsigned STALL_LIMIT = 2000;
   localparam int unsigned HOLD_CYCLES = 80;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   req_payload_type            req_payload;
   logic                       rsp_valid;
   logic                       rsp_ready;
   rsp_payload_type            rsp_payload;
   logic                       csr_write_enable;
   logic [CSR_WIDTH-1:0]       csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_write_data;

   int unsigned                mismatch_count;
   int unsigned                pending_replies;

   // Idle percentages for both sides, and the count of long receiver holds asked for.
   int unsigned                req_idle_pct;
   int unsigned                rsp_idle_pct;
   int unsigned                holds_asked;

   pool_chunk_allocator_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   pool_chunk_allocator_unit_checker checker_inst (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .mismatch_count   (mismatch_count),
      .pending_replies  (pending_replies)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Receiver side. It drops ready at random, and when the stimulus asks for a hold it
   // keeps ready low for a long stretch, counted here, so the output register fills and
   // the unit has to stall the sender.
   initial begin
      int unsigned hold_left;
      int unsigned holds_served;
      hold_left = 0;
      holds_served = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (holds_served != holds_asked) begin
            holds_served = holds_asked;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   // Watchdog: ends the run if neither channel moves anything for too long.
   initial begin
      int unsigned quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Offers one request and waits for its transfer. Valid stays high into the next
   // request unless a random gap follows, so back-to-back transfers happen too.
   task automatic send_request(input op_type kind, input logic [IDX_WIDTH-1:0] idx);
      req_valid <= 1'b1;
      req_payload <= '{op: kind, chunk_index: idx};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   // Stops offering and waits until every predicted result has been returned. The first
   // edge lets the checker count the request that was accepted last.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_replies != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // Writes both registers back to back; only called while the unit is idle.
   task automatic write_config(input logic [CSR_DATA_WIDTH-1:0] first_chunks,
                               input logic [CSR_DATA_WIDTH-1:0] bytes_each);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_CHUNKS_PER_BLOCK;
      csr_write_data <= first_chunks;
      @(posedge clock);
      csr_index <= CSR_CHUNK_BYTES;
      csr_write_data <= bytes_each;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // Random mix of allocations and releases. Releases lean toward low indices, where
   // the handed-out chunks live, but any index can be released.
   task automatic run_random(input int unsigned count, input int unsigned alloc_pct);
      op_type               kind;
      logic [IDX_WIDTH-1:0] idx;
      for (int unsigned n = 0; n < count; n++) begin
         kind = ($urandom_range(99) < alloc_pct) ? OP_ALLOCATE : OP_RELEASE;
         if ($urandom_range(1) == 0)
            idx = IDX_WIDTH'($urandom_range(0, 63));
         else
            idx = IDX_WIDTH'($urandom_range(0, POOL_CHUNKS - 1));
         send_request(kind, idx);
      end
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_payload <= '0;
      csr_write_enable <= 1'b0;
      csr_index <= CSR_CHUNKS_PER_BLOCK;
      csr_write_data <= '0;
      req_idle_pct = 33;
      rsp_idle_pct = 33;
      holds_asked = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The first allocation opens a block with the reset settings. Releases of the
      // extreme and alternating indices then come back in last-in, first-out order.
      send_request(OP_ALLOCATE, 10'h3FF);
      send_request(OP_RELEASE, 10'h3FF);
      send_request(OP_RELEASE, 10'h000);
      send_request(OP_RELEASE, 10'h2AA);
      send_request(OP_RELEASE, 10'h155);
      repeat (4) send_request(OP_ALLOCATE, 10'h000);
      drain_results();

      // A zero-size first block: the fresh chunks of the open block are used up, and the
      // allocation after them finds no block it can open.
      write_config(13'd0, 13'd4096);
      repeat (16) send_request(OP_ALLOCATE, 10'h155);
      drain_results();

      // The next block would run past the index space at both of the largest sizes.
      write_config(13'd1024, 13'd1);
      send_request(OP_ALLOCATE, 10'h000);
      drain_results();
      write_config(13'd2047, 13'd8191);
      send_request(OP_ALLOCATE, 10'h000);
      drain_results();

      // The smallest settings open a block again.
      write_config(13'd1, 13'd1);
      send_request(OP_ALLOCATE, 10'h000);
      drain_results();

      // Random traffic with idling on both sides; halfway the receiver holds off for a
      // long stretch while requests keep coming.
      write_config(13'd3, CSR_DATA_WIDTH'($urandom_range(1, 4096)));
      run_random(50, 55);
      holds_asked++;
      run_random(60, 55);
      drain_results();

      // A long stretch with no idling at all.
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      write_config(CSR_DATA_WIDTH'($urandom_range(1, 16)),
                   CSR_DATA_WIDTH'($urandom_range(1, 4096)));
      run_random(120, 50);
      drain_results();

      // Allocation-heavy traffic with a large first block, running the pool dry.
      req_idle_pct = 33;
      rsp_idle_pct = 33;
      write_config(CSR_DATA_WIDTH'($urandom_range(1, 1024)),
                   CSR_DATA_WIDTH'($urandom_range(1, 4096)));
      run_random(120, 85);
      holds_asked++;
      run_random(40, 60);
      drain_results();
      repeat (5) @(posedge clock);

      if (mismatch_count == 0 && pending_replies == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
